@@ sv/ptc_pkg.sv @@
// Shared types for the pressure/temperature compensation block.
// Calibration word bundle and the divider cell word. No dependencies.
package ptc_pkg;

	localparam int DivBits = 64;

	// calibration words, unpacked from the register file
	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cal_t;

	// results that ride alongside the division
	typedef struct packed {
		logic [31:0] temp_centi;
		logic [31:0] fine_temp;
		logic        nonzero;
		logic        negate;
	} div_side_t;

	// one divider cell's word: partial remainder, dividend/quotient shifter, divisor
	typedef struct packed {
		logic [DivBits-1:0] rem;
		logic [DivBits-1:0] nq;
		logic [DivBits-1:0] den;
		div_side_t          side;
	} div_word_t;

endpackage

@@ sv/ptc_div_cell.sv @@
// One restoring-division cell: retires one quotient bit per item.
// Depends on ptc_pkg.
module ptc_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  ptc_pkg::div_word_t in_word,
	output logic              out_valid,
	output ptc_pkg::div_word_t out_word
);
	import ptc_pkg::*;

	logic [DivBits:0] shifted;
	logic [DivBits:0] diff;
	div_word_t        next_word;

	always_comb begin
		shifted   = {in_word.rem, in_word.nq[DivBits-1]};
		diff      = shifted - {1'b0, in_word.den};
		next_word = in_word;
		next_word.nq = {in_word.nq[DivBits-2:0], ~diff[DivBits]};
		if (diff[DivBits]) begin
			next_word.rem = shifted[DivBits-1:0];
		end else begin
			next_word.rem = diff[DivBits-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= next_word;
		end
	end

endmodule

@@ sv/ptc_front.sv @@
// Front pipeline: temperature compensation and the pressure terms up to the
// division, ending in magnitude/sign prep for the divider chain. Depends on ptc_pkg.
module ptc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	input  ptc_pkg::cal_t      cal,
	output logic               out_valid,
	output ptc_pkg::div_word_t out_word
);
	import ptc_pkg::*;

	localparam int Stages = 12;

	logic [Stages-1:0] vld_q;

	// stage registers
	logic [31:0] a_s1, d_s1;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7;
	logic [19:0] adcp_s8, adcp_s9;
	logic [31:0] pa_s2, dd_s2;
	logic [31:0] va_s3, x_s3;
	logic [31:0] tfine_s4, tfine_s5, tfine_s6, tfine_s7, tfine_s8, tfine_s9;
	logic [31:0] tfine_s10, tfine_s11;
	logic [31:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11;
	logic signed [32:0] v1_s5;
	logic [63:0] sq_s6;
	logic signed [48:0] pv5_s6, pv2_s6, pv5_s7, pv2_s7;
	logic [63:0] v2a_s7, m3_s7;
	logic [63:0] v2_s8, v1b_s8, v2_s9, m1_s9;
	logic [63:0] den_s10, num0_s10, den_s11, num_s11;

	// combinational terms
	logic signed [47:0] pa_full;
	logic signed [31:0] dd_sh;
	logic signed [47:0] x_full;
	logic signed [31:0] va_n, vb_n;
	logic [31:0]        tf5;
	logic signed [65:0] sq_full;
	logic signed [79:0] v2a_full, m3_full;
	logic [63:0]        m3_sh;
	logic [79:0]        m1_full;
	logic [20:0]        pdiff;
	logic [75:0]        num_full;

	always_comb begin
		pa_full  = $signed(a_s1) * cal.t2;
		dd_sh    = $signed(dd_s2) >>> 12;
		x_full   = dd_sh * cal.t3;
		va_n     = $signed(va_s3);
		vb_n     = $signed(x_s3) >>> 14;
		tf5      = {tfine_s4[29:0], 2'b00} + tfine_s4 + 32'd128;
		sq_full  = v1_s5 * v1_s5;
		v2a_full = $signed(sq_s6) * cal.p6;
		m3_full  = $signed(sq_s6) * cal.p3;
		m3_sh    = $signed(m3_s7) >>> 8;
		m1_full  = (v1b_s8 + 64'h0000_8000_0000_0000) * cal.p1;
		pdiff    = 21'd1048576 - {1'b0, adcp_s9};
		num_full = num0_s10 * 12'd3125;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Stages-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// temperature, 32-bit wrap
			a_s1    <= {15'b0, raw_temperature[19:3]} - {15'b0, cal.t1, 1'b0};
			d_s1    <= {16'b0, raw_temperature[19:4]} - {16'b0, cal.t1};
			adcp_s1 <= raw_pressure;
			pa_s2   <= pa_full[31:0];
			dd_s2   <= d_s1 * d_s1;
			adcp_s2 <= adcp_s1;
			va_s3   <= 32'($signed(pa_s2) >>> 11);
			x_s3    <= x_full[31:0];
			adcp_s3 <= adcp_s2;
			tfine_s4 <= 32'(va_n + vb_n);
			adcp_s4  <= adcp_s3;
			tc_s5    <= 32'($signed(tf5) >>> 8);
			v1_s5    <= {tfine_s4[31], tfine_s4} - 33'sd128000;
			tfine_s5 <= tfine_s4;
			adcp_s5  <= adcp_s4;
			// pressure, 64-bit wrap
			sq_s6    <= sq_full[63:0];
			pv5_s6   <= v1_s5 * cal.p5;
			pv2_s6   <= v1_s5 * cal.p2;
			tc_s6    <= tc_s5;
			tfine_s6 <= tfine_s5;
			adcp_s6  <= adcp_s5;
			v2a_s7   <= v2a_full[63:0];
			m3_s7    <= m3_full[63:0];
			pv5_s7   <= pv5_s6;
			pv2_s7   <= pv2_s6;
			tc_s7    <= tc_s6;
			tfine_s7 <= tfine_s6;
			adcp_s7  <= adcp_s6;
			v2_s8    <= v2a_s7 + {pv5_s7[46:0], 17'b0}
				+ {{13{cal.p4[15]}}, cal.p4, 35'b0};
			v1b_s8   <= m3_sh + {{3{pv2_s7[48]}}, pv2_s7, 12'b0};
			tc_s8    <= tc_s7;
			tfine_s8 <= tfine_s7;
			adcp_s8  <= adcp_s7;
			v2_s9    <= v2_s8;
			m1_s9    <= m1_full[63:0];
			tc_s9    <= tc_s8;
			tfine_s9 <= tfine_s8;
			adcp_s9  <= adcp_s8;
			den_s10  <= 64'($signed(m1_s9) >>> 33);
			num0_s10 <= {12'b0, pdiff, 31'b0} - v2_s9;
			tc_s10   <= tc_s9;
			tfine_s10 <= tfine_s9;
			num_s11  <= num_full[63:0];
			den_s11  <= den_s10;
			tc_s11   <= tc_s10;
			tfine_s11 <= tfine_s10;
			// magnitudes into the divider chain
			out_word.rem  <= '0;
			out_word.nq   <= num_s11[63] ? (64'd0 - num_s11) : num_s11;
			out_word.den  <= den_s11[63] ? (64'd0 - den_s11) : den_s11;
			out_word.side.temp_centi <= tc_s11;
			out_word.side.fine_temp  <= tfine_s11;
			out_word.side.nonzero    <= |den_s11;
			out_word.side.negate     <= num_s11[63] ^ den_s11[63];
		end
	end

	assign out_valid = vld_q[Stages-1];

endmodule

@@ sv/ptc_back.sv @@
// Back pipeline: quotient sign fix and the second-order pressure correction.
// Depends on ptc_pkg.
module ptc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  ptc_pkg::div_word_t in_word,
	input  ptc_pkg::cal_t      cal,
	output logic               out_valid,
	output logic [31:0]        temperature_centi,
	output logic [31:0]        fine_temperature,
	output logic [31:0]        pressure_q24_8,
	output logic               pressure_valid
);
	import ptc_pkg::*;

	localparam int Stages = 5;

	logic [Stages-1:0] vld_q;

	logic [63:0] p_s1;
	logic [39:0] p_s2, p_s3, p_s4;
	div_side_t   side_s1, side_s2, side_s3, side_s4;
	logic [63:0] ll_s2, w2m_s2, w2m_s3, w2m_s4;
	logic [31:0] cross_s2;
	logic [63:0] pss_s3, w1m_s4;

	logic [63:0]        ps;
	logic signed [79:0] w2_full, w1_full;
	logic [39:0]        sum40;
	logic [31:0]        pres32;

	always_comb begin
		ps      = $signed(p_s1) >>> 13;
		w2_full = $signed(p_s1) * cal.p8;
		w1_full = $signed(pss_s3) * cal.p9;
		sum40   = p_s4 + {w1m_s4[63], w1m_s4[63:25]} + w2m_s4[58:19];
		pres32  = sum40[39:8] + {{12{cal.p7[15]}}, cal.p7, 4'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Stages-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1     <= in_word.side.negate ? (64'd0 - in_word.nq) : in_word.nq;
			side_s1  <= in_word.side;
			// ps*ps low 64: lo*lo plus twice the cross term
			ll_s2    <= ps[31:0] * ps[31:0];
			cross_s2 <= ps[31:0] * ps[63:32];
			w2m_s2   <= w2_full[63:0];
			p_s2     <= p_s1[39:0];
			side_s2  <= side_s1;
			pss_s3   <= ll_s2 + {cross_s2[30:0], 33'b0};
			w2m_s3   <= w2m_s2;
			p_s3     <= p_s2;
			side_s3  <= side_s2;
			w1m_s4   <= w1_full[63:0];
			w2m_s4   <= w2m_s3;
			p_s4     <= p_s3;
			side_s4  <= side_s3;
			temperature_centi <= side_s4.temp_centi;
			fine_temperature  <= side_s4.fine_temp;
			pressure_q24_8    <= side_s4.nonzero ? pres32 : 32'd0;
			pressure_valid    <= side_s4.nonzero;
		end
	end

	assign out_valid = vld_q[Stages-1];

endmodule

@@ sv/pressure_temperature_compensation_top.sv @@
// Top level of the pressure/temperature compensation block.
// Depends on ptc_pkg, ptc_front, ptc_div_cell and ptc_back.

// Integer compensation of a barometric sensor sample pair. Each s_tdata transfer
// carries a raw 20-bit temperature and a raw 20-bit pressure reading; each m_tdata
// transfer returns the temperature in 0.01 degree, the fine temperature and the
// pressure in Q24.8 pascals (low 32 bits), with m_tuser set when the pressure is
// good and clear when the pressure divisor came out zero (pressure then reads 0).
// One pair is accepted per clock while the pipe advances. The path runs through
// 12 front stages, a chain of 64 restoring-division cells (one quotient bit each),
// and 5 back stages ending in the output register. The whole pipe advances when
// the output register is empty or its result is taken, so s_tready drops only
// while a result waits on m_tready. Calibration lives in four APB registers at
// byte offsets 0x00 cal_temp (T1[47:32] T2[31:16] T3[15:0]), 0x08 cal_press_a
// (P1 P2 P3 P4), 0x10 cal_press_b (P5 P6 P7 P8) and 0x18 cal_p9; T1 and P1 are
// unsigned, the rest signed. Write them only while the pipe is empty.
module pressure_temperature_compensation_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [19:0] raw_temperature, [39:20] raw_pressure
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [31:0] temperature_centi, [63:32] fine_temperature,
	                               // [95:64] pressure_q24_8
	output logic        m_tuser,   // [0] pressure_valid
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import ptc_pkg::*;

	localparam logic [1:0] RegCalTemp   = 2'd0;
	localparam logic [1:0] RegCalPressA = 2'd1;
	localparam logic [1:0] RegCalPressB = 2'd2;
	localparam logic [1:0] RegCalP9     = 2'd3;

	logic [47:0] cal_temp_q;
	logic [63:0] cal_press_a_q;
	logic [63:0] cal_press_b_q;
	logic [15:0] cal_p9_q;
	cal_t        cal;
	logic        adv;
	logic        cfg_wr;

	logic      cell_vld  [0:DivBits];
	div_word_t cell_word [0:DivBits];

	logic [31:0] temp_centi, fine_temp, pres;
	logic        pres_ok;

	// register file
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q    <= '0;
			cal_press_a_q <= '0;
			cal_press_b_q <= '0;
			cal_p9_q      <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				RegCalTemp:   cal_temp_q    <= pwdata[47:0];
				RegCalPressA: cal_press_a_q <= pwdata;
				RegCalPressB: cal_press_b_q <= pwdata;
				RegCalP9:     cal_p9_q      <= pwdata[15:0];
				default:      cal_p9_q      <= cal_p9_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			RegCalTemp:   prdata = {16'b0, cal_temp_q};
			RegCalPressA: prdata = cal_press_a_q;
			RegCalPressB: prdata = cal_press_b_q;
			RegCalP9:     prdata = {48'b0, cal_p9_q};
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		cal.t1 = cal_temp_q[47:32];
		cal.t2 = cal_temp_q[31:16];
		cal.t3 = cal_temp_q[15:0];
		cal.p1 = cal_press_a_q[63:48];
		cal.p2 = cal_press_a_q[47:32];
		cal.p3 = cal_press_a_q[31:16];
		cal.p4 = cal_press_a_q[15:0];
		cal.p5 = cal_press_b_q[63:48];
		cal.p6 = cal_press_b_q[47:32];
		cal.p7 = cal_press_b_q[31:16];
		cal.p8 = cal_press_b_q[15:0];
		cal.p9 = cal_p9_q;
	end

	// whole pipe moves when the output register frees up
	assign adv      = ~m_tvalid | m_tready;
	assign s_tready = adv;

	ptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (adv),
		.in_valid        (s_tvalid),
		.raw_temperature (s_tdata[19:0]),
		.raw_pressure    (s_tdata[39:20]),
		.cal             (cal),
		.out_valid       (cell_vld[0]),
		.out_word        (cell_word[0])
	);

	// divider: one quotient bit per cell, MSB first
	for (genvar i = 0; i < DivBits; i++) begin : g_cell
		ptc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (cell_vld[i]),
			.in_word   (cell_word[i]),
			.out_valid (cell_vld[i+1]),
			.out_word  (cell_word[i+1])
		);
	end

	ptc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (adv),
		.in_valid          (cell_vld[DivBits]),
		.in_word           (cell_word[DivBits]),
		.cal               (cal),
		.out_valid         (m_tvalid),
		.temperature_centi (temp_centi),
		.fine_temperature  (fine_temp),
		.pressure_q24_8    (pres),
		.pressure_valid    (pres_ok)
	);

	assign m_tdata = {pres, fine_temp, temp_centi};
	assign m_tuser = pres_ok;

`ifndef SYNTHESIS
	a_stall_only_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	a_bad_pressure_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[95:64] == 32'd0)
		else $error("pressure nonzero with divisor flagged zero");

	a_centi_from_fine: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:0] ==
			32'(($signed(m_tdata[63:32]) * 32'sd5 + 32'sd128) >>> 8))
		else $error("temperature out of step with fine temperature");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		cell_vld[DivBits] && cell_word[DivBits].den != '0
			|-> cell_word[DivBits].rem < cell_word[DivBits].den)
		else $error("division remainder not below divisor");
`endif

endmodule
